@@ src/bba_pkg.sv @@
// Shared types and codes of the bitmap block allocator.
// No dependencies; imported by the word unit, the top level and the checker.
package bba_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESERVE = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_NONE_FREE    = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2
  } status_e;

  // What the word unit does to one map word
  typedef enum logic [1:0] {
    WOP_FIND  = 2'd0,
    WOP_SET   = 2'd1,
    WOP_CLEAR = 2'd2
  } wop_e;

  typedef enum logic [2:0] {
    S_INIT = 3'b001,
    S_IDLE = 3'b010,
    S_WALK = 3'b100
  } state_e;

  typedef struct packed {
    logic found;      // word holds a free block (find)
    logic last_word;  // word holds the last block of the run
  } word_stat_t;

endpackage

@@ src/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/bba_word_unit.sv @@
// Shared word unit: lowest-free-bit search and run mask set/clear on one map word.
// Depends on bba_pkg.
module bba_word_unit import bba_pkg::*; #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned IDX_W     = 10,
  parameter int unsigned BASE_W    = 11,
  localparam int unsigned OFF_W    = $clog2(WORD_BITS)
) (
  input  wop_e                 op_i,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [BASE_W-1:0]    base_i,   // block number of bit 0
  input  logic [IDX_W-1:0]     first_i,
  input  logic [IDX_W-1:0]     last_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [OFF_W-1:0]     off_o,
  output word_stat_t           stat_o
);

  localparam logic [BASE_W-1:0] WB_B  = BASE_W'(WORD_BITS);
  localparam logic [OFF_W-1:0]  TOP_B = OFF_W'(WORD_BITS - 1);

  logic [BASE_W-1:0]    first_ext, last_ext, lo_gap, hi_gap;
  logic                 after_base, run_later, last_word;
  logic [OFF_W-1:0]     lo_off, hi_off;
  logic [WORD_BITS-1:0] ones, mask, pick;

  assign ones      = '1;
  assign first_ext = BASE_W'(first_i);
  assign last_ext  = BASE_W'(last_i);
  assign lo_gap    = first_ext - base_i;
  assign hi_gap    = last_ext - base_i;

  assign after_base = first_ext > base_i;
  assign run_later  = after_base && (lo_gap >= WB_B);  // run starts in a later word
  assign last_word  = hi_gap < WB_B;
  assign lo_off     = after_base ? lo_gap[OFF_W-1:0] : '0;
  assign hi_off     = last_word ? hi_gap[OFF_W-1:0] : TOP_B;
  assign mask       = run_later ? '0 : ((ones << lo_off) & (ones >> (TOP_B - hi_off)));

  // lowest set bit wins
  always_comb begin
    off_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        off_o = OFF_W'(i);
      end
    end
  end

  assign stat_o = '{found: |word_i, last_word: last_word};
  assign pick   = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_o;

  always_comb begin
    case (op_i)
      WOP_FIND:  word_o = word_i & ~pick;
      WOP_SET:   word_o = word_i | mask;
      WOP_CLEAR: word_o = word_i & ~mask;
      default:   word_o = word_i;
    endcase
  end

endmodule

@@ src/bitmap_block_allocator.sv @@
// Bitmap free-block allocator top level: sequencer, map RAM and free count.
// Depends on bba_pkg, bba_ram and bba_word_unit.

// Tracks MAP_BLOCKS blocks in a RAM of WORD_BITS-bit words (1 = free) plus a
// free count. An item is taken when start_i is high and busy_o is low; its
// one result appears for a single cycle with done_o, and the receiver cannot
// stall it. After reset a clearing pass writes the map, one word per cycle,
// with busy_o high. Rejected and empty-run items give their result in the
// cycle after acceptance with no busy time. Other items walk the map from
// word 0 through the single RAM read port, one word per cycle, up to the word
// holding the lowest free block (allocate; the last word when the map is
// full) or the last block of the run (free or range).
// A new item may be started in the cycle its predecessor's result is shown.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int unsigned MAP_BLOCKS = 1024,
  parameter int unsigned WORD_BITS  = 32,
  localparam int unsigned IDX_W     = $clog2(MAP_BLOCKS),
  localparam int unsigned CNT_W     = $clog2(MAP_BLOCKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       kind_i,
  input  logic [IDX_W-1:0] start_block_i,
  input  logic [CNT_W-1:0] block_count_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [IDX_W-1:0] block_index_o,
  output logic [CNT_W-1:0] free_blocks_o
);

  localparam int unsigned MAP_WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned OFF_W     = $clog2(WORD_BITS);
  localparam int unsigned BASE_W    = $clog2(MAP_BLOCKS + WORD_BITS);
  localparam int unsigned LAST_BITS = MAP_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;

  localparam logic [AW-1:0]        LAST_W    = AW'(MAP_WORDS - 1);
  localparam logic [BASE_W-1:0]    WB_B      = BASE_W'(WORD_BITS);
  localparam logic [CNT_W-1:0]     FULL_CNT  = CNT_W'(MAP_BLOCKS);
  localparam logic [CNT_W:0]       FULL_SUM  = (CNT_W+1)'(MAP_BLOCKS);
  localparam logic [CNT_W-1:0]     ONE_CNT   = CNT_W'(1);
  localparam logic [WORD_BITS-1:0] ALL_FREE  = '1;
  localparam logic [WORD_BITS-1:0] TAIL_FREE = ALL_FREE >> (WORD_BITS - LAST_BITS);

  state_e            state_q, state_d;
  wop_e              op_q, op_d;
  logic [IDX_W-1:0]  first_q, first_d, last_q, last_d;
  logic [CNT_W-1:0]  delta_q, delta_d;
  logic [AW-1:0]     rd_w_q, rd_w_d, p_w_q, p_w_d;
  logic [BASE_W-1:0] rd_base_q, rd_base_d, p_base_q, p_base_d;
  logic              p_vld_q, p_vld_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [IDX_W-1:0]  index_q, index_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, unit_word;
  logic [OFF_W-1:0]     unit_off;
  word_stat_t           unit_stat;

  logic [CNT_W:0]   run_end;
  logic [CNT_W-1:0] room;
  logic             finish;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_w_q),
    .rdata_o (ram_rdata)
  );

  bba_word_unit #(
    .WORD_BITS (WORD_BITS),
    .IDX_W     (IDX_W),
    .BASE_W    (BASE_W)
  ) u_unit (
    .op_i    (op_q),
    .word_i  (ram_rdata),
    .base_i  (p_base_q),
    .first_i (first_q),
    .last_i  (last_q),
    .word_o  (unit_word),
    .off_o   (unit_off),
    .stat_o  (unit_stat)
  );

  assign run_end = (CNT_W+1)'(start_block_i) + (CNT_W+1)'(block_count_i);
  assign room    = FULL_CNT - total_q;

  assign finish = p_vld_q && ((op_q == WOP_FIND) ? (unit_stat.found || (p_w_q == LAST_W))
                                                 : unit_stat.last_word);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    first_d   = first_q;
    last_d    = last_q;
    delta_d   = delta_q;
    rd_w_d    = rd_w_q;
    rd_base_d = rd_base_q;
    p_w_d     = p_w_q;
    p_base_d  = p_base_q;
    p_vld_d   = p_vld_q;
    total_d   = total_q;
    done_d    = 1'b0;
    status_d  = status_q;
    index_d   = index_q;
    ram_we    = 1'b0;
    ram_waddr = p_w_q;
    ram_wdata = unit_word;

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = rd_w_q;
        ram_wdata = (rd_w_q == LAST_W) ? TAIL_FREE : ALL_FREE;
        if (rd_w_q == LAST_W) begin
          rd_w_d  = '0;
          state_d = S_IDLE;
        end else begin
          rd_w_d = rd_w_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          rd_w_d    = '0;
          rd_base_d = '0;
          p_vld_d   = 1'b0;
          index_d   = '0;
          first_d   = start_block_i;
          last_d    = start_block_i;
          delta_d   = ONE_CNT;
          case (kind_i)
            KIND_ALLOC: begin
              op_d    = WOP_FIND;
              state_d = S_WALK;
            end
            KIND_FREE: begin
              if ((CNT_W+1)'(start_block_i) >= FULL_SUM) begin
                done_d   = 1'b1;
                status_d = STAT_OUT_OF_RANGE;
              end else begin
                op_d    = WOP_SET;
                state_d = S_WALK;
              end
            end
            default: begin
              op_d    = (kind_i == KIND_RELEASE) ? WOP_SET : WOP_CLEAR;
              last_d  = IDX_W'(run_end - 1'b1);
              delta_d = block_count_i;
              if (run_end > FULL_SUM) begin
                done_d   = 1'b1;
                status_d = STAT_OUT_OF_RANGE;
              end else if (block_count_i == '0) begin
                done_d   = 1'b1;
                status_d = STAT_OK;
              end else begin
                state_d = S_WALK;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        // read word k+1 while word k is modified and written back
        if (rd_w_q != LAST_W) begin
          rd_w_d    = rd_w_q + 1'b1;
          rd_base_d = rd_base_q + WB_B;
        end
        p_vld_d  = 1'b1;
        p_w_d    = rd_w_q;
        p_base_d = rd_base_q;
        ram_we   = p_vld_q && ((op_q != WOP_FIND) || unit_stat.found);
        if (finish) begin
          state_d   = S_IDLE;
          p_vld_d   = 1'b0;
          rd_w_d    = '0;
          rd_base_d = '0;
          done_d    = 1'b1;
          status_d  = STAT_OK;
          if (op_q == WOP_FIND) begin
            if (unit_stat.found) begin
              index_d = IDX_W'(p_base_q + BASE_W'(unit_off));
              total_d = (total_q == '0) ? '0 : total_q - 1'b1;
            end else begin
              status_d = STAT_NONE_FREE;
            end
          end else if (op_q == WOP_SET) begin
            total_d = (delta_q >= room) ? FULL_CNT : total_q + delta_q;
          end else begin
            total_d = (delta_q >= total_q) ? '0 : total_q - delta_q;
          end
        end
      end

      default: begin
        state_d = S_INIT;
        rd_w_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      rd_w_q    <= '0;
      rd_base_q <= '0;
      p_vld_q   <= 1'b0;
      total_q   <= FULL_CNT;
      done_q    <= 1'b0;
      status_q  <= STAT_OK;
      index_q   <= '0;
    end else begin
      state_q   <= state_d;
      rd_w_q    <= rd_w_d;
      rd_base_q <= rd_base_d;
      p_vld_q   <= p_vld_d;
      total_q   <= total_d;
      done_q    <= done_d;
      status_q  <= status_d;
      index_q   <= index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    first_q  <= first_d;
    last_q   <= last_d;
    delta_q  <= delta_d;
    p_w_q    <= p_w_d;
    p_base_q <= p_base_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign block_index_o = index_q;
  assign free_blocks_o = total_q;

endmodule

@@ src/bba_checker.sv @@
// Port-level checks of the bitmap block allocator, bound to its top level.
// Depends on bba_pkg and bitmap_block_allocator.
module bba_checker import bba_pkg::*; #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned CNT_W = 11
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             busy_o,
  input logic             done_o,
  input logic [1:0]       status_o,
  input logic [IDX_W-1:0] block_index_o,
  input logic [CNT_W-1:0] free_blocks_o
);

  // a walking item never shows a result before its own end
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |-> !done_o)
    else $error("result strobe while busy");

  // free count only moves with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !$stable(free_blocks_o) |-> done_o)
    else $error("free count changed without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && (status_o != STAT_OK)) |-> (block_index_o == '0))
    else $error("failed item carries a block index");

endmodule

bind bitmap_block_allocator bba_checker #(
  .IDX_W (IDX_W),
  .CNT_W (CNT_W)
) u_bba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .block_index_o (block_index_o),
  .free_blocks_o (free_blocks_o)
);

@@ bench/tb.sv @@
// Testbench for bitmap_block_allocator: random and directed requests, checked
// against a bit-level free map and free count kept by the scoreboard class.
// Depends on bba_pkg and the allocator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int unsigned MAP_BLOCKS = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned N_RANDOM   = 2000;
  localparam int unsigned CYCLE_CAP  = 500_000;
  localparam int unsigned TAIL_WAIT  = 40;  // a full map walk plus margin

  typedef struct {
    status_e              status;
    logic [IDX_W-1:0]     index;
    logic [CNT_W-1:0]     free_blocks;
  } reply_t;

  // Tracks the free map and count, and the replies still owed by the block.
  class free_map_tracker;
    bit [MAP_BLOCKS-1:0] free_bits = '1;
    int unsigned         free_total = MAP_BLOCKS;
    reply_t              owed[$];
    int unsigned         errors;

    function void raise_count(int unsigned n);
      free_total = (n >= MAP_BLOCKS - free_total) ? MAP_BLOCKS : free_total + n;
    endfunction

    function void lower_count(int unsigned n);
      free_total = (n >= free_total) ? 0 : free_total - n;
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction

    function void note_request(kind_e kind, int unsigned sblk, int unsigned cnt);
      reply_t r;
      bit     hit;
      r.status = STAT_OK;
      r.index  = '0;
      hit      = 1'b0;
      case (kind)
        KIND_ALLOC: begin
          for (int unsigned i = 0; i < MAP_BLOCKS; i++) begin
            if (!hit && free_bits[i]) begin
              hit     = 1'b1;
              r.index = IDX_W'(i);
            end
          end
          if (hit) begin
            free_bits[r.index] = 1'b0;
            lower_count(1);
          end else begin
            r.status = STAT_NONE_FREE;
          end
        end
        KIND_FREE: begin
          if (sblk >= MAP_BLOCKS) begin
            r.status = STAT_OUT_OF_RANGE;
          end else begin
            free_bits[sblk] = 1'b1;
            raise_count(1);
          end
        end
        default: begin
          if (sblk + cnt > MAP_BLOCKS) begin
            r.status = STAT_OUT_OF_RANGE;
          end else if (cnt != 0) begin
            for (int unsigned i = sblk; i < sblk + cnt; i++)
              free_bits[i] = (kind == KIND_RELEASE);
            if (kind == KIND_RELEASE) raise_count(cnt);
            else lower_count(cnt);
          end
        end
      endcase
      r.free_blocks = CNT_W'(free_total);
      owed.insert(owed.size(), r);
    endfunction

    function void check_reply(logic [1:0] st, logic [IDX_W-1:0] idx,
                              logic [CNT_W-1:0] fb);
      reply_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no item pending: status %0d index %0d free %0d",
                   $realtime, st, idx, fb);
        return;
      end
      want = owed.pop_front();
      if (st !== want.status || idx !== want.index || fb !== want.free_blocks) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: expected status %0d index %0d free %0d, got %0d %0d %0d",
                   $realtime, want.status, want.index, want.free_blocks, st, idx, fb);
      end
    endfunction
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             start_i       = 1'b0;
  logic [1:0]       kind_i        = KIND_ALLOC;
  logic [IDX_W-1:0] start_block_i = '0;
  logic [CNT_W-1:0] block_count_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [1:0]       status_o;
  logic [IDX_W-1:0] block_index_o;
  logic [CNT_W-1:0] free_blocks_o;

  free_map_tracker tracker = new();
  int unsigned     cycles;
  int unsigned     burst_left;

  bitmap_block_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .start_block_i (start_block_i),
    .block_count_i (block_count_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .block_index_o (block_index_o),
    .free_blocks_o (free_blocks_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      tracker.note_request(kind_e'(kind_i), 32'(start_block_i), 32'(block_count_i));
    if (rst_ni && done_o)
      tracker.check_reply(status_o, block_index_o, free_blocks_o);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_item(kind_e kind, logic [IDX_W-1:0] sblk, logic [CNT_W-1:0] cnt);
    int unsigned gap;
    if (burst_left == 0 && $urandom_range(0, 99) == 0)
      burst_left = $urandom_range(20, 60);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    kind_i        <= kind;
    start_block_i <= sblk;
    block_count_i <= cnt;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Hold off until every owed result has come back.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  initial begin
    int unsigned sel;
    int unsigned sblk;
    int unsigned cnt;
    kind_e       kind;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unused fields at their extremes
    send_item(KIND_ALLOC, 10'd1023, 11'd2047);
    send_item(KIND_ALLOC, 10'd0, 11'd0);
    send_item(KIND_FREE, 10'd0, 11'd2047);
    send_item(KIND_FREE, 10'd5, 11'd0);         // already free
    send_item(KIND_FREE, 10'd1023, 11'd1);      // count pinned at the top
    send_item(KIND_RESERVE, 10'd1023, 11'd1);
    send_item(KIND_RESERVE, 10'd1023, 11'd2);   // one past the end
    send_item(KIND_RELEASE, 10'd0, 11'd0);      // empty run
    send_item(KIND_RESERVE, 10'd1000, 11'd0);
    send_item(KIND_RESERVE, 10'd0, 11'd2047);
    send_item(KIND_RELEASE, 10'd1, 11'd1024);
    send_item(KIND_RESERVE, 10'd0, 11'd1024);   // map full
    send_item(KIND_ALLOC, 10'd512, 11'd512);
    send_item(KIND_RESERVE, 10'd10, 11'd5);     // count pinned at zero
    send_item(KIND_RELEASE, 10'd992, 11'd32);   // last word only
    send_item(KIND_ALLOC, 10'd0, 11'd0);
    send_item(KIND_RELEASE, 10'd30, 11'd4);     // crosses a word boundary
    send_item(KIND_ALLOC, 10'd0, 11'd0);
    send_item(KIND_RESERVE, 10'd20, 11'd40);    // mixed bits
    send_item(KIND_FREE, 10'd1023, 11'd0);
    send_item(KIND_RELEASE, 10'd0, 11'd1024);
    send_item(KIND_ALLOC, 10'd0, 11'd0);
    send_item(KIND_FREE, 10'd512, 11'd2047);
    drain();

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      sel  = $urandom_range(0, 99);
      sblk = $urandom_range(0, 1023);
      cnt  = $urandom_range(0, 2047);
      if (sel < 38) begin
        kind = KIND_ALLOC;
      end else if (sel < 58) begin
        kind = KIND_FREE;
        // low blocks are the ones most likely handed out
        if ($urandom_range(0, 1)) sblk = $urandom_range(0, 127);
      end else begin
        kind = $urandom_range(0, 1) ? KIND_RELEASE : KIND_RESERVE;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: cnt = $urandom_range(1, 40);
          6, 7:             cnt = $urandom_range(41, 1024);
          8:                ;  // anything the field holds
          default:          cnt = MAP_BLOCKS - sblk + $urandom_range(0, 1);
        endcase
        if (cnt <= 40 && $urandom_range(0, 1)) sblk = $urandom_range(0, 255);
      end
      send_item(kind, IDX_W'(sblk), CNT_W'(cnt));
      if (n % 400 == 399 && $urandom_range(0, 1)) drain();
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ bitmap_block_allocator.f @@
src/bba_pkg.sv
src/bba_ram.sv
src/bba_word_unit.sv
src/bitmap_block_allocator.sv
src/bba_checker.sv
bench/tb.sv
